>>> src/dcd_pkg.sv
`timescale 1ns / 1ps

package dcd_pkg;

    // Field widths
    localparam int VAL_W      = 24;
    localparam int CONF_W     = 23;
    localparam int CLS_W      = 7;
    localparam int POS_W      = 7;
    localparam int PIX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int SCALE_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Product widths
    localparam int PCONF_W = 2 * VAL_W;          // objectness * best score
    localparam int PEDGE_W = VAL_W + 2 + SCALE_W; // (2c - s) * scale
    localparam int PSIZE_W = VAL_W + 1 + SCALE_W; // size * scale

    localparam logic [POS_W-1:0]  POS_MAX     = 7'd127;
    localparam logic [CLS_W-1:0]  MAX_CLASSES = 7'd80;
    localparam logic [DIM_W-1:0]  IMG_MAX     = 13'd4096;
    localparam logic [CONF_W-1:0] CONF_MAX    = 23'h7FFFFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;

    // Register reset values
    localparam logic [CONF_W-1:0]  RST_THRESHOLD = 23'd1024;
    localparam logic [SCALE_W-1:0] RST_SCALE     = 24'd4096;
    localparam logic [DIM_W-1:0]   RST_IMAGE     = 13'd640;

    // Live configuration, image sizes already limited to IMG_MAX
    typedef struct packed {
        logic                mode;
        logic [CONF_W-1:0]   thr;
        logic [SCALE_W-1:0]  sx;
        logic [SCALE_W-1:0]  sy;
        logic [DIM_W-1:0]    wimg;
        logic [DIM_W-1:0]    himg;
    } t_cfg;

    // One finished candidate vector
    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] w;
        logic signed [VAL_W-1:0] h;
        logic signed [VAL_W-1:0] obj;
        logic signed [VAL_W-1:0] best;
        logic [CLS_W-1:0]        cls;
    } t_cand;

endpackage

>>> src/detection_candidate_decode_unit.sv
`timescale 1ns / 1ps
// Detection candidate decoder.
// Input channel (i_valid / o_stall): one signed Q12.12 element of a candidate
// vector per request, i_last_element set on the final one. Elements 0..3 are
// x, y, w, h; in mode 1 element 4 is objectness; the rest are class scores.
// One element is taken every cycle unless o_stall is high; the running argmax
// is a single compare. Output channel (o_valid / i_stall): at most one result
// per vector. The snapshot loads on the edge that takes the last element, then
// multiply, clamp and output register follow before o_valid rises. Vectors may
// follow each other with no gap. Vectors whose confidence is not above
// threshold or whose box is empty give no result.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): register index and
// data; write only while no vector is in flight.
// Reset returns all registers to defaults and clears the partial vector.
// While a valid result is stalled, the output register holds; the pipeline
// fills and o_stall rises once the last-element snapshot cannot move on.
module detection_candidate_decode_unit
    import dcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VAL_W-1:0]      i_element_value,
    input  logic                  i_last_element,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CLS_W-1:0]      o_class_index,
    output logic [CONF_W-1:0]     o_confidence,
    output logic [PIX_W-1:0]      o_box_left,
    output logic [PIX_W-1:0]      o_box_top,
    output logic [DIM_W-1:0]      o_box_width,
    output logic [DIM_W-1:0]      o_box_height,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_cand cand;
    logic  cand_valid;
    logic  pipe_ready;
    logic  acc_ready;
    logic  accept;

    assign o_stall = !acc_ready;
    assign accept  = i_valid && acc_ready;

    dcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dcd_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_value      (i_element_value),
        .i_last       (i_last_element),
        .i_mode       (cfg.mode),
        .i_next_ready (pipe_ready),
        .o_ready      (acc_ready),
        .o_cand_valid (cand_valid),
        .o_cand       (cand)
    );

    dcd_box_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cand_valid  (cand_valid),
        .i_cand        (cand),
        .o_ready       (pipe_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_class_index (o_class_index),
        .o_confidence  (o_confidence),
        .o_box_left    (o_box_left),
        .o_box_top     (o_box_top),
        .o_box_width   (o_box_width),
        .o_box_height  (o_box_height)
    );

endmodule

>>> src/dcd_cfg_regs.sv
`timescale 1ns / 1ps

module dcd_cfg_regs
    import dcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic               r_mode;
    logic [CONF_W-1:0]  r_thr;
    logic [SCALE_W-1:0] r_sx;
    logic [SCALE_W-1:0] r_sy;
    logic [DIM_W-1:0]   r_img_w;
    logic [DIM_W-1:0]   r_img_h;

    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_thr   <= RST_THRESHOLD;
            r_sx    <= RST_SCALE;
            r_sy    <= RST_SCALE;
            r_img_w <= RST_IMAGE;
            r_img_h <= RST_IMAGE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DECODE_MODE:     r_mode  <= i_cfg_data[0];
                REG_SCORE_THRESHOLD: r_thr   <= i_cfg_data[CONF_W-1:0];
                REG_SCALE_X:         r_sx    <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_Y:         r_sy    <= i_cfg_data[SCALE_W-1:0];
                REG_IMAGE_WIDTH:     r_img_w <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:    r_img_h <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Image sizes above the limit act as the limit
    always_comb begin
        o_cfg.mode = r_mode;
        o_cfg.thr  = r_thr;
        o_cfg.sx   = r_sx;
        o_cfg.sy   = r_sy;
        o_cfg.wimg = (r_img_w > IMG_MAX) ? IMG_MAX : r_img_w;
        o_cfg.himg = (r_img_h > IMG_MAX) ? IMG_MAX : r_img_h;
    end

endmodule

>>> src/dcd_accum.sv
`timescale 1ns / 1ps

module dcd_accum
    import dcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_last,
    input  logic             i_mode,
    input  logic             i_next_ready,
    output logic             o_ready,
    output logic             o_cand_valid,
    output t_cand            o_cand
);

    logic [POS_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_coords [4];
    logic signed [VAL_W-1:0] r_obj;
    logic signed [VAL_W-1:0] r_best;
    logic [CLS_W-1:0]        r_cls;

    logic [POS_W-1:0]        n_pos;
    logic signed [VAL_W-1:0] n_coords [4];
    logic signed [VAL_W-1:0] n_obj;
    logic signed [VAL_W-1:0] n_best;
    logic [CLS_W-1:0]        n_cls;

    // Vector as it stands with the current element taken in
    logic signed [VAL_W-1:0] u_coords [4];
    logic signed [VAL_W-1:0] u_obj;
    logic signed [VAL_W-1:0] u_best;
    logic [CLS_W-1:0]        u_cls;

    logic                    r_v1;
    t_cand                   r_cand;

    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0]        first_class;
    logic [POS_W-1:0]        cls_off;

    assign v           = $signed(i_value);
    assign first_class = i_mode ? 7'd5 : 7'd4;
    assign cls_off     = r_pos - first_class;
    assign o_ready     = !r_v1 || i_next_ready;

    // Place the element by position, running strict-greater argmax
    always_comb begin
        u_coords = r_coords;
        u_obj    = r_obj;
        u_best   = r_best;
        u_cls    = r_cls;
        if (i_accept) begin
            if (r_pos < 7'd4) begin
                u_coords[r_pos[1:0]] = v;
            end else if (i_mode && r_pos == 7'd4) begin
                u_obj = v;
            end else if (r_pos >= first_class) begin
                if (cls_off < MAX_CLASSES && v > r_best) begin
                    u_best = v;
                    u_cls  = cls_off;
                end
            end
        end
    end

    // Advance position; a last element clears the vector
    always_comb begin
        n_pos    = r_pos;
        n_coords = u_coords;
        n_obj    = u_obj;
        n_best   = u_best;
        n_cls    = u_cls;
        if (i_accept) begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 7'd1;
            end
            if (i_last) begin
                n_pos = '0;
                for (int i = 0; i < 4; i++) begin
                    n_coords[i] = '0;
                end
                n_obj  = '0;
                n_best = '0;
                n_cls  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_obj  <= '0;
            r_best <= '0;
            r_cls  <= '0;
            for (int i = 0; i < 4; i++) begin
                r_coords[i] <= '0;
            end
        end else begin
            r_pos    <= n_pos;
            r_coords <= n_coords;
            r_obj    <= n_obj;
            r_best   <= n_best;
            r_cls    <= n_cls;
        end
    end

    // Snapshot register for a finished vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_cand.x    <= u_coords[0];
            r_cand.y    <= u_coords[1];
            r_cand.w    <= u_coords[2];
            r_cand.h    <= u_coords[3];
            r_cand.obj  <= u_obj;
            r_cand.best <= u_best;
            r_cand.cls  <= u_cls;
        end
    end

    assign o_cand_valid = r_v1;
    assign o_cand       = r_cand;

endmodule

>>> src/dcd_box_pipe.sv
`timescale 1ns / 1ps

module dcd_box_pipe
    import dcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_cand_valid,
    input  t_cand             i_cand,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CLS_W-1:0]  o_class_index,
    output logic [CONF_W-1:0] o_confidence,
    output logic [PIX_W-1:0]  o_box_left,
    output logic [PIX_W-1:0]  o_box_top,
    output logic [DIM_W-1:0]  o_box_width,
    output logic [DIM_W-1:0]  o_box_height
);

    logic ready_out;
    logic ready3;

    // ---------------- Stage 2: products ----------------
    logic                      r_v2;
    logic signed [PCONF_W-1:0] r_pc;
    logic signed [PEDGE_W-1:0] r_pl;
    logic signed [PEDGE_W-1:0] r_pt;
    logic signed [PSIZE_W-1:0] r_pw;
    logic signed [PSIZE_W-1:0] r_ph;
    logic [CONF_W-1:0]         r_best2;
    logic [CLS_W-1:0]          r_cls2;

    logic signed [VAL_W+1:0]   edge_l;
    logic signed [VAL_W+1:0]   edge_t;
    logic signed [SCALE_W:0]   sxs;
    logic signed [SCALE_W:0]   sys;

    // 2x - w and 2y - h, scales as non-negative signed operands
    assign edge_l = {{1{i_cand.x[VAL_W-1]}}, i_cand.x, 1'b0}
                  - {{2{i_cand.w[VAL_W-1]}}, i_cand.w};
    assign edge_t = {{1{i_cand.y[VAL_W-1]}}, i_cand.y, 1'b0}
                  - {{2{i_cand.h[VAL_W-1]}}, i_cand.h};
    assign sxs    = $signed({1'b0, i_cfg.sx});
    assign sys    = $signed({1'b0, i_cfg.sy});

    assign o_ready = !r_v2 || ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_ready) begin
            r_v2 <= i_cand_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pc    <= i_cand.obj * i_cand.best;
            r_pl    <= edge_l * sxs;
            r_pt    <= edge_t * sys;
            r_pw    <= i_cand.w * sxs;
            r_ph    <= i_cand.h * sys;
            // best score never drops below zero
            r_best2 <= i_cand.best[CONF_W-1:0];
            r_cls2  <= i_cand.cls;
        end
    end

    // ---------------- Stage 3: confidence, corner clamp ----------------
    logic               r_v3;
    logic [CONF_W-1:0]  r_conf3;
    logic [CLS_W-1:0]   r_cls3;
    logic [PIX_W-1:0]   r_left3;
    logic [PIX_W-1:0]   r_top3;
    logic [VAL_W-1:0]   r_bw3;
    logic [VAL_W-1:0]   r_bh3;
    logic               r_bw_ok3;
    logic               r_bh_ok3;

    logic               pc_pos;
    logic               pc_sat;
    logic [CONF_W-1:0]  conf;
    logic [VAL_W-1:0]   left_raw;
    logic [VAL_W-1:0]   top_raw;
    logic [DIM_W-1:0]   wm1;
    logic [DIM_W-1:0]   hm1;
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   top;

    assign ready3 = !r_v3 || ready_out;

    // Mode 1: objectness * best >> 12, floor at zero, saturate; mode 0: best score
    assign pc_pos = !r_pc[PCONF_W-1] && (r_pc != '0);
    assign pc_sat = |r_pc[PCONF_W-2:CONF_W+12];
    always_comb begin
        if (i_cfg.mode) begin
            if (!pc_pos) begin
                conf = '0;
            end else if (pc_sat) begin
                conf = CONF_MAX;
            end else begin
                conf = r_pc[CONF_W+11:12];
            end
        end else begin
            conf = r_best2;
        end
    end

    // Negative corners land on zero; a zero image size also gives zero
    assign left_raw = r_pl[PEDGE_W-2:25];
    assign top_raw  = r_pt[PEDGE_W-2:25];
    assign wm1      = i_cfg.wimg - 13'd1;
    assign hm1      = i_cfg.himg - 13'd1;

    always_comb begin
        if (r_pl[PEDGE_W-1] || i_cfg.wimg == '0) begin
            left = '0;
        end else if (left_raw > {{(VAL_W-DIM_W){1'b0}}, wm1}) begin
            left = wm1[PIX_W-1:0];
        end else begin
            left = left_raw[PIX_W-1:0];
        end
        if (r_pt[PEDGE_W-1] || i_cfg.himg == '0) begin
            top = '0;
        end else if (top_raw > {{(VAL_W-DIM_W){1'b0}}, hm1}) begin
            top = hm1[PIX_W-1:0];
        end else begin
            top = top_raw[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (ready3) begin
            r_v3 <= r_v2 && (conf > i_cfg.thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r_conf3  <= conf;
            r_cls3   <= r_cls2;
            r_left3  <= left;
            r_top3   <= top;
            r_bw3    <= r_pw[PSIZE_W-2:24];
            r_bh3    <= r_ph[PSIZE_W-2:24];
            r_bw_ok3 <= !r_pw[PSIZE_W-1];
            r_bh_ok3 <= !r_ph[PSIZE_W-1];
        end
    end

    // ---------------- Output register: size clamp, emptiness test ----------------
    logic               r_o_valid;
    logic [DIM_W-1:0]   room_w;
    logic [DIM_W-1:0]   room_h;
    logic [DIM_W-1:0]   bw;
    logic [DIM_W-1:0]   bh;
    logic               emit;

    assign ready_out = !r_o_valid || !i_stall;
    assign room_w    = i_cfg.wimg - {1'b0, r_left3};
    assign room_h    = i_cfg.himg - {1'b0, r_top3};

    always_comb begin
        bw   = (r_bw3 > {{(VAL_W-DIM_W){1'b0}}, room_w}) ? room_w : r_bw3[DIM_W-1:0];
        bh   = (r_bh3 > {{(VAL_W-DIM_W){1'b0}}, room_h}) ? room_h : r_bh3[DIM_W-1:0];
        emit = r_v3 && r_bw_ok3 && r_bh_ok3 && (bw != '0) && (bh != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ready_out) begin
            r_o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out) begin
            o_class_index <= r_cls3;
            o_confidence  <= r_conf3;
            o_box_left    <= r_left3;
            o_box_top     <= r_top3;
            o_box_width   <= bw;
            o_box_height  <= bh;
        end
    end

    assign o_valid = r_o_valid;

    // ---------------- Checks ----------------
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_box_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({2'b0, o_box_left} + {1'b0, o_box_width}) <= {1'b0, i_cfg.wimg})
        else $error("box runs past image width");

    a_box_in_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({2'b0, o_box_top} + {1'b0, o_box_height}) <= {1'b0, i_cfg.himg})
        else $error("box runs past image height");

    a_box_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box_width != '0) && (o_box_height != '0))
        else $error("empty box emitted");

    a_conf_above_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_confidence > i_cfg.thr)
        else $error("confidence not above threshold");

endmodule

>>> bench/detection_candidate_decode_unit_test.sv
`timescale 1ns / 1ps

module detection_candidate_decode_unit_test;
    import dcd_pkg::*;

    localparam int     RANDOM_ITEMS  = 750;
    localparam int     MAX_PHASES    = 40;
    localparam int     PHASE_ITEMS   = 120;
    localparam int     HOLDOFF       = 8;      // pipeline is 4 deep, leave margin
    localparam int     END_DRAIN     = 20;
    localparam int     Q_ONE         = 4096;
    localparam longint EDGE_DIV      = 64'sd33554432;  // 2^25
    localparam longint SIZE_DIV      = 64'sd16777216;  // 2^24

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [CONF_W-1:0] conf;
        logic [PIX_W-1:0]  left;
        logic [PIX_W-1:0]  top;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } box_result_t;

    typedef enum logic {ROW_ELEMENT, ROW_WRITE} row_kind_e;
    typedef enum logic [1:0] {EXP_FROM_MODEL, EXP_NO_BOX, EXP_BOX} box_check_e;
    typedef enum logic [1:0] {
        STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY
    } stall_style_e;

    typedef struct {
        row_kind_e          kind;
        logic [VAL_W-1:0]   val;      // element value, or register data
        logic               last;
        logic [CFG_IDX_W-1:0] reg_idx;
        box_check_e         check;
        box_result_t        box;
    } plan_row_t;

    // DUT connections
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [VAL_W-1:0]      i_element_value;
    logic                  i_last_element;
    logic                  o_valid;
    logic                  i_stall;
    logic [CLS_W-1:0]      o_class_index;
    logic [CONF_W-1:0]     o_confidence;
    logic [PIX_W-1:0]      o_box_left;
    logic [PIX_W-1:0]      o_box_top;
    logic [DIM_W-1:0]      o_box_width;
    logic [DIM_W-1:0]      o_box_height;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    detection_candidate_decode_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element_value (i_element_value),
        .i_last_element  (i_last_element),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_class_index   (o_class_index),
        .o_confidence    (o_confidence),
        .o_box_left      (o_box_left),
        .o_box_top       (o_box_top),
        .o_box_width     (o_box_width),
        .o_box_height    (o_box_height),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder copy: configuration
    logic               cfg_mode;
    logic [CONF_W-1:0]  cfg_thr;
    logic [SCALE_W-1:0] cfg_sx;
    logic [SCALE_W-1:0] cfg_sy;
    logic [DIM_W-1:0]   cfg_wimg;
    logic [DIM_W-1:0]   cfg_himg;

    // Decoder copy: partial candidate vector
    logic [POS_W-1:0]        cand_pos;
    logic signed [VAL_W-1:0] cand_best;
    logic [CLS_W-1:0]        cand_cls;
    logic signed [VAL_W-1:0] cand_coord [4];
    logic signed [VAL_W-1:0] cand_obj;

    box_result_t expected_boxes [$];
    plan_row_t   plan [$];
    int          mismatches      = 0;
    int          items_sent      = 0;
    int          burst_left      = 0;

    // Append to the expected results / the directed table
    task automatic queue_box(input box_result_t b);
        expected_boxes.insert(expected_boxes.size(), b);
    endtask

    task automatic add_row(input plan_row_t row);
        plan.insert(plan.size(), row);
    endtask

    task automatic clear_candidate();
        cand_pos  = '0;
        cand_best = '0;
        cand_cls  = '0;
        foreach (cand_coord[k]) cand_coord[k] = '0;
        cand_obj  = '0;
    endtask

    // Take one element in; on the last one decode the box
    task automatic decode_element(input logic [VAL_W-1:0] v_bits, input logic last,
                                  output bit hit, output box_result_t r);
        logic signed [VAL_W-1:0] v;
        int unsigned             first;
        longint                  conf, prod, left, top, bw, bh, wimg, himg;
        longint                  x, y, w, h;
        logic [CLS_W-1:0]        cls;
        v     = v_bits;
        hit   = 1'b0;
        r     = '0;
        first = cfg_mode ? 5 : 4;
        if (cand_pos < 4) begin
            cand_coord[cand_pos[1:0]] = v;
        end else if (cfg_mode && cand_pos == 4) begin
            cand_obj = v;
        end else if (cand_pos >= first) begin
            if ((cand_pos - first) < MAX_CLASSES && v > cand_best) begin
                cand_best = v;
                cand_cls  = CLS_W'(cand_pos - first);
            end
        end
        if (cand_pos < POS_MAX) cand_pos++;
        if (!last) return;

        if (cfg_mode) begin
            prod = longint'(cand_obj) * longint'(cand_best);
            conf = (prod <= 0) ? 0 : (prod >>> 12);
            if (conf > longint'(CONF_MAX)) conf = longint'(CONF_MAX);
        end else begin
            conf = cand_best;
        end
        x   = cand_coord[0];
        y   = cand_coord[1];
        w   = cand_coord[2];
        h   = cand_coord[3];
        cls = cand_cls;
        clear_candidate();

        if (conf <= longint'(cfg_thr)) return;

        wimg = (cfg_wimg > IMG_MAX) ? longint'(IMG_MAX) : longint'(cfg_wimg);
        himg = (cfg_himg > IMG_MAX) ? longint'(IMG_MAX) : longint'(cfg_himg);
        // integer division truncates toward zero
        left = ((2 * x - w) * longint'(cfg_sx)) / EDGE_DIV;
        top  = ((2 * y - h) * longint'(cfg_sy)) / EDGE_DIV;
        bw   = (w * longint'(cfg_sx)) / SIZE_DIV;
        bh   = (h * longint'(cfg_sy)) / SIZE_DIV;

        if (left > wimg - 1) left = wimg - 1;
        if (left < 0) left = 0;
        if (top > himg - 1) top = himg - 1;
        if (top < 0) top = 0;
        if (bw > wimg - left) bw = wimg - left;
        if (bh > himg - top) bh = himg - top;
        if (bw <= 0 || bh <= 0) return;

        hit      = 1'b1;
        r.cls    = cls;
        r.conf   = conf[CONF_W-1:0];
        r.left   = left[PIX_W-1:0];
        r.top    = top[PIX_W-1:0];
        r.width  = bw[DIM_W-1:0];
        r.height = bh[DIM_W-1:0];
    endtask

    // Drive one element request; bursts with random gaps between them
    task automatic send_elem(input logic [VAL_W-1:0] v, input logic last,
                             input box_check_e check, input box_result_t typed_box);
        int          gap;
        bit          hit;
        box_result_t box;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid         <= 1'b1;
        i_element_value <= v;
        i_last_element  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_element(v, last, hit, box);
        case (check)
            EXP_FROM_MODEL: if (hit) begin
                queue_box(box);
            end
            EXP_BOX: begin
                queue_box(typed_box);
            end
            default: ;
        endcase
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Stop the sender and let every pending result come out
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(negedge i_clk);
        repeat (HOLDOFF) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_DECODE_MODE:     cfg_mode = data[0];
            REG_SCORE_THRESHOLD: cfg_thr  = data[CONF_W-1:0];
            REG_SCALE_X:         cfg_sx   = data[SCALE_W-1:0];
            REG_SCALE_Y:         cfg_sy   = data[SCALE_W-1:0];
            REG_IMAGE_WIDTH:     cfg_wimg = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT:    cfg_himg = data[DIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic box_result_t mk_box(int cls, int conf, int left, int top, int bw, int bh);
        box_result_t b;
        b.cls    = CLS_W'(cls);
        b.conf   = CONF_W'(conf);
        b.left   = PIX_W'(left);
        b.top    = PIX_W'(top);
        b.width  = DIM_W'(bw);
        b.height = DIM_W'(bh);
        return b;
    endfunction

    function automatic plan_row_t elem_row(logic [VAL_W-1:0] v, logic last,
                                           box_check_e check, box_result_t box);
        plan_row_t row;
        row.kind    = ROW_ELEMENT;
        row.val     = v;
        row.last    = last;
        row.reg_idx = REG_DECODE_MODE;
        row.check   = check;
        row.box     = box;
        return row;
    endfunction

    function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
        plan_row_t row;
        row.kind    = ROW_WRITE;
        row.val     = data;
        row.last    = 1'b0;
        row.reg_idx = idx;
        row.check   = EXP_NO_BOX;
        row.box     = '0;
        return row;
    endfunction

    // Coordinate in model pixels, now and then any 24-bit value
    function automatic logic [VAL_W-1:0] rand_coord(int span);
        if ($urandom_range(0, 7) == 0) return VAL_W'($urandom());
        return VAL_W'($urandom_range(0, span) * Q_ONE + $urandom_range(0, Q_ONE - 1));
    endfunction

    function automatic logic [VAL_W-1:0] rand_score();
        case ($urandom_range(0, 9))
            0:       return VAL_W'($urandom());
            1:       return VAL_W'(0 - int'($urandom_range(1, 8192)));
            default: return VAL_W'($urandom_range(0, Q_ONE));
        endcase
    endfunction

    // One random candidate vector: mostly well formed, some noise and short ones
    task automatic random_vector();
        int  style, n, first;
        bit  tail_big;
        logic [VAL_W-1:0] v;
        style    = $urandom_range(0, 19);
        first    = cfg_mode ? 5 : 4;
        tail_big = $urandom_range(0, 1);
        if (style == 0) begin
            // noise, last flag anywhere
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                send_elem(VAL_W'($urandom()), (i == n - 1) || ($urandom_range(0, 5) == 0),
                          EXP_FROM_MODEL, '0);
        end else if (style == 1) begin
            // short vector, ends before the class scores
            n = $urandom_range(1, first);
            for (int i = 0; i < n; i++)
                send_elem(rand_coord(800), i == n - 1, EXP_FROM_MODEL, '0);
        end else begin
            n = (style == 2) ? $urandom_range(76, 136) : $urandom_range(1, 12);
            send_elem(rand_coord(800), 1'b0, EXP_FROM_MODEL, '0);
            send_elem(rand_coord(800), 1'b0, EXP_FROM_MODEL, '0);
            send_elem(rand_coord(300), 1'b0, EXP_FROM_MODEL, '0);
            send_elem(rand_coord(300), 1'b0, EXP_FROM_MODEL, '0);
            if (cfg_mode) send_elem(rand_score(), 1'b0, EXP_FROM_MODEL, '0);
            for (int c = 0; c < n; c++) begin
                // with tail_big, scores past the class limit get large to win if counted
                if (c >= 80 && tail_big) v = VAL_W'($urandom_range(Q_ONE, 8388607));
                else                     v = rand_score();
                send_elem(v, c == n - 1, EXP_FROM_MODEL, '0);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Result checker
    box_result_t want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_boxes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d %0d %0d %0d %0d %0d",
                         $time, o_class_index, o_confidence, o_box_left, o_box_top,
                         o_box_width, o_box_height);
                mismatches++;
            end else begin
                want = expected_boxes.pop_front();
                compare_field("class_index", 32'(want.cls),    32'(o_class_index));
                compare_field("confidence",  32'(want.conf),   32'(o_confidence));
                compare_field("box_left",    32'(want.left),   32'(o_box_left));
                compare_field("box_top",     32'(want.top),    32'(o_box_top));
                compare_field("box_width",   32'(want.width),  32'(o_box_width));
                compare_field("box_height",  32'(want.height), 32'(o_box_height));
            end
        end
    end

    // Receiver stall, switching between four random styles
    stall_style_e stall_style = STALL_NONE;
    int           stall_left  = 0;
    int           stall_tick  = 0;
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_style = stall_style_e'($urandom_range(0, 3));
                stall_left  = $urandom_range(100, 400);
            end
            stall_left--;
            stall_tick++;
            case (stall_style)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_SPARSE:   i_stall <= ($urandom_range(0, 9) < 3);
                STALL_PERIODIC: i_stall <= ((stall_tick % 7) < 3);
                default:        i_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Main sequence
    initial begin
        int phase;
        int phase_start;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_element_value = '0;
        i_last_element  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_DECODE_MODE;
        i_cfg_data      = '0;
        cfg_mode        = 1'b0;
        cfg_thr         = RST_THRESHOLD;
        cfg_sx          = RST_SCALE;
        cfg_sy          = RST_SCALE;
        cfg_wimg        = RST_IMAGE;
        cfg_himg        = RST_IMAGE;
        clear_candidate();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: default registers, box centred at 100,200 size 50x40, class 1 wins
        add_row(elem_row(24'd409600, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd819200, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd204800, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd163840, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd2048,   1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd3072,   1'b1, EXP_BOX, mk_box(1, 3072, 75, 180, 50, 40)));
        // all maximum: box clamped to the image corner
        add_row(elem_row(24'h7FFFFF, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h7FFFFF, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h7FFFFF, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h7FFFFF, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h7FFFFF, 1'b1, EXP_BOX, mk_box(0, 8388607, 639, 639, 1, 1)));
        // all minimum coords, score equal to threshold: nothing
        add_row(elem_row(24'h800000, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h800000, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h800000, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h800000, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd1024,   1'b1, EXP_NO_BOX, '0));
        // single element vector, no scores
        add_row(elem_row(24'h123456, 1'b1, EXP_NO_BOX, '0));
        // objectness mode, product saturates
        add_row(write_row(REG_DECODE_MODE, 24'd1));
        add_row(elem_row(24'd409600, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd819200, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd204800, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd163840, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h7FFFFF, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'h7FFFFF, 1'b1, EXP_BOX, mk_box(0, 8388607, 75, 180, 50, 40)));
        // mode switched back to 0 halfway through a vector
        add_row(elem_row(24'd409600, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd819200, 1'b0, EXP_FROM_MODEL, '0));
        add_row(write_row(REG_DECODE_MODE, 24'd0));
        add_row(elem_row(24'd204800, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd163840, 1'b0, EXP_FROM_MODEL, '0));
        add_row(elem_row(24'd3072,   1'b1, EXP_FROM_MODEL, '0));

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE) begin
                settle_block();
                write_reg(plan[k].reg_idx, plan[k].val);
            end else begin
                send_elem(plan[k].val, plan[k].last, plan[k].check, plan[k].box);
            end
        end

        // Random phases, each with its own register setting
        phase      = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS && phase < MAX_PHASES) begin
            settle_block();
            case (phase % 8)
                0: begin
                    write_reg(REG_DECODE_MODE,     24'd0);
                    write_reg(REG_SCORE_THRESHOLD, 24'(RST_THRESHOLD));
                    write_reg(REG_SCALE_X,         RST_SCALE);
                    write_reg(REG_SCALE_Y,         RST_SCALE);
                    write_reg(REG_IMAGE_WIDTH,     24'(RST_IMAGE));
                    write_reg(REG_IMAGE_HEIGHT,    24'(RST_IMAGE));
                end
                1: begin
                    write_reg(REG_DECODE_MODE,     24'd1);
                    write_reg(REG_SCORE_THRESHOLD, 24'd0);
                    write_reg(REG_SCALE_X,         24'hFFFFFF);
                    write_reg(REG_SCALE_Y,         24'hFFFFFF);
                    write_reg(REG_IMAGE_WIDTH,     24'd4096);
                    write_reg(REG_IMAGE_HEIGHT,    24'd1);
                end
                2: begin
                    write_reg(REG_DECODE_MODE,     24'd0);
                    write_reg(REG_SCORE_THRESHOLD, 24'h7FFFFF);
                    write_reg(REG_SCALE_X,         24'd0);
                    write_reg(REG_SCALE_Y,         24'd0);
                    write_reg(REG_IMAGE_WIDTH,     24'd8191);
                    write_reg(REG_IMAGE_HEIGHT,    24'd0);
                end
                3: begin
                    write_reg(REG_DECODE_MODE,     24'd1);
                    write_reg(REG_SCORE_THRESHOLD, 24'd2048);
                    write_reg(REG_SCALE_X,         24'd8192);
                    write_reg(REG_SCALE_Y,         24'd2048);
                    write_reg(REG_IMAGE_WIDTH,     24'd4097);
                    write_reg(REG_IMAGE_HEIGHT,    24'd4096);
                end
                default: begin
                    write_reg(REG_DECODE_MODE,     24'($urandom_range(0, 1)));
                    write_reg(REG_SCORE_THRESHOLD, 24'($urandom_range(0, 4096)));
                    write_reg(REG_SCALE_X,         24'($urandom_range(1024, 16384)));
                    write_reg(REG_SCALE_Y,         24'($urandom_range(1024, 16384)));
                    write_reg(REG_IMAGE_WIDTH,     24'($urandom_range(1, 4096)));
                    write_reg(REG_IMAGE_HEIGHT,    24'($urandom_range(1, 4096)));
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS)
                random_vector();
            phase++;
        end

        // Drain and finish
        i_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(negedge i_clk);
        repeat (END_DRAIN) @(negedge i_clk);
        if (mismatches == 0 && expected_boxes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
